// ----- rtl/core/b64_pkg.sv -----
package b64_pkg;

  // Number of interior '=' characters that decode can hold back.
  localparam int MAX_HELD_PADS = 4;
  localparam int HELD_W = $clog2(MAX_HELD_PADS + 1);

  // Longest sextet run one character can release: three collected sextets,
  // every held pad and the character itself.
  localparam int SEQ_SEXTETS = MAX_HELD_PADS + 4;
  localparam int SEQ_W = 6 * SEQ_SEXTETS;
  localparam int T_W = $clog2(SEQ_SEXTETS + 1);
  localparam int SH_W = $clog2(SEQ_W + 1);

  // Most results one item can cause (at least four characters in encode).
  localparam int MAX_UNITS = (SEQ_W / 8 > 4) ? SEQ_W / 8 : 4;
  localparam int UNIT_W = $clog2(MAX_UNITS + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       no_data;
    logic       end_of_message;
    logic       pad_overflow;
  } result_t;

  // One entry of the work queue: a left-aligned bit string to be cut into
  // characters (encode) or bytes (decode), followed by '=' padding.
  typedef struct packed {
    logic [SEQ_W-1:0]  bits;
    logic              decode;
    logic [UNIT_W-1:0] units;
    logic [1:0]        pads;
    logic              eom;
    logic              ovf;
  } cmd_t;

  function automatic logic [7:0] alphabet_char(input logic [5:0] s);
    logic [7:0] c;
    if (s < 6'd26) begin
      c = 8'h41 + {2'b00, s};
    end else if (s < 6'd52) begin
      c = 8'h61 + {2'b00, s} - 8'd26;
    end else if (s < 6'd62) begin
      c = 8'h30 + {2'b00, s} - 8'd52;
    end else if (s == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

  function automatic logic [5:0] sextet_of(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = c - 8'h61 + 8'd26;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30 + 8'd52;
    end else if (c == 8'h2B) begin
      v = 8'd62;
    end else begin
      v = 8'd63;
    end
    return v[5:0];
  endfunction

endpackage

// ----- rtl/core/b64_front.sv -----
module b64_front
  import b64_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    mode_we,
  input  logic    mode_wdata,
  input  logic    push,
  input  item_t   item,
  output logic    full,
  input  logic    q_full,
  output logic    q_push,
  output cmd_t    q_cmd
);

  logic              mode;
  logic [23:0]       gbits;
  logic [1:0]        gcount;
  logic [HELD_W-1:0] held;

  logic [23:0]       gbits_next;
  logic [1:0]        gcount_next;
  logic [HELD_W-1:0] held_next;

  logic              accept;
  logic              last;
  logic              is_pad;
  logic [5:0]        sext;

  // Encode path.
  logic [23:0]       enc_seq;
  logic [2:0]        enc_t;

  // Decode path.
  logic [T_W-1:0]    dl;
  logic [T_W-1:0]    dt;
  logic [T_W-1:0]    groups;
  logic [SH_W-1:0]   sh_count;
  logic [SH_W-1:0]   sh_run;
  logic [SH_W-1:0]   sh_bits;
  logic [SH_W-1:0]   sh_groups;
  logic [SEQ_W-1:0]  ones;
  logic [SEQ_W-1:0]  fill;
  logic [SEQ_W-1:0]  tail;
  logic [SEQ_W-1:0]  dseq;
  logic [SEQ_W-1:0]  dshift;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign last   = item.last_byte;
  assign is_pad = (item.data_byte == PAD_CHAR);
  assign sext   = sextet_of(item.data_byte);

  assign enc_seq = gbits | ({item.data_byte, 16'h0000} >> ({3'b000, gcount} * 5'd8));
  assign enc_t   = {1'b0, gcount} + 3'd1;

  // The decode run is the collected sextets, then every held pad as all ones,
  // then the new sextet, all packed from the top of the word.
  assign dl        = T_W'(gcount) + T_W'(held);
  assign dt        = is_pad ? T_W'(gcount) : dl + T_W'(1);
  assign groups    = dt >> 2;
  assign sh_count  = SH_W'(gcount) * SH_W'(6);
  assign sh_run    = SH_W'(dl) * SH_W'(6);
  assign sh_bits   = SH_W'(dt) * SH_W'(6);
  assign sh_groups = SH_W'(groups) * SH_W'(24);
  assign ones      = {SEQ_W{1'b1}};
  assign fill      = (ones >> sh_count) & ~(ones >> sh_run);
  assign tail      = {sext, {(SEQ_W - 6){1'b0}}} >> sh_run;
  assign dseq      = {gbits, {(SEQ_W - 24){1'b0}}} | (is_pad ? '0 : (fill | tail));
  assign dshift    = dseq << sh_groups;

  always_comb begin
    gbits_next  = gbits;
    gcount_next = gcount;
    held_next   = held;
    q_push      = 1'b0;
    q_cmd       = '0;
    q_cmd.eom   = last;

    if (mode == MODE_ENCODE) begin
      q_cmd.bits = {enc_seq, {(SEQ_W - 24){1'b0}}};
      if (enc_t == 3'd3) begin
        q_cmd.units = UNIT_W'(4);
      end else if (last) begin
        q_cmd.units = UNIT_W'(enc_t) + UNIT_W'(1);
        q_cmd.pads  = 2'(3'd3 - enc_t);
      end
      q_push = accept && (last || enc_t == 3'd3);
      if (last || enc_t == 3'd3) begin
        gbits_next  = '0;
        gcount_next = '0;
      end else begin
        gbits_next  = enc_seq;
        gcount_next = enc_t[1:0];
      end
    end else begin
      q_cmd.decode = 1'b1;
      q_cmd.bits   = dseq;
      if (is_pad && !last) begin
        if (held < HELD_W'(MAX_HELD_PADS)) begin
          held_next = held + HELD_W'(1);
        end else begin
          q_cmd.ovf = 1'b1;
          q_push    = accept;
        end
      end else begin
        if (last) begin
          q_cmd.units = UNIT_W'(sh_bits >> 3);
        end else begin
          q_cmd.units = UNIT_W'(groups * T_W'(3));
        end
        q_push      = accept && (last || groups != '0);
        gbits_next  = dshift[SEQ_W-1 -: 24];
        gcount_next = dt[1:0];
        held_next   = '0;
      end
      if (last) begin
        gbits_next  = '0;
        gcount_next = '0;
        held_next   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_ENCODE;
      gbits  <= '0;
      gcount <= '0;
      held   <= '0;
    end else if (mode_we) begin
      mode   <= mode_wdata;
      gbits  <= '0;
      gcount <= '0;
      held   <= '0;
    end else if (accept) begin
      gbits  <= gbits_next;
      gcount <= gcount_next;
      held   <= held_next;
    end
  end

endmodule

// ----- rtl/core/b64_queue.sv -----
module b64_queue
  import b64_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t wdata,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t rdata
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign rdata = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/core/b64_back.sv -----
module b64_back
  import b64_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  input  cmd_t    q_cmd,
  output logic    q_pop,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  logic              out_valid;
  logic [UNIT_W-1:0] k;
  logic [UNIT_W-1:0] total;
  logic [UNIT_W-1:0] k_last;
  logic              advance;
  logic              at_last;
  logic [SEQ_W-1:0]  oct_shift;
  logic [SEQ_W-1:0]  sex_shift;
  result_t           step;

  assign total     = q_cmd.units + UNIT_W'(q_cmd.pads);
  assign k_last    = (total == '0) ? '0 : total - UNIT_W'(1);
  assign at_last   = (k == k_last);
  assign advance   = q_valid && (!out_valid || pop);
  assign q_pop     = advance && at_last;
  assign empty     = !out_valid;
  assign oct_shift = q_cmd.bits << (SH_W'(k) * SH_W'(8));
  assign sex_shift = q_cmd.bits << (SH_W'(k) * SH_W'(6));

  always_comb begin
    step = '0;
    if (total == '0) begin
      // A transaction with nothing to print only flags end of message or overflow.
      step.no_data      = 1'b1;
      step.pad_overflow = q_cmd.ovf;
    end else if (k < q_cmd.units) begin
      if (q_cmd.decode) begin
        step.out_byte = oct_shift[SEQ_W-1 -: 8];
      end else begin
        step.out_byte = alphabet_char(sex_shift[SEQ_W-1 -: 6]);
      end
    end else begin
      step.out_byte = PAD_CHAR;
    end
    step.end_of_message = q_cmd.eom && at_last;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      k         <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        k         <= at_last ? '0 : k + UNIT_W'(1);
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/base64_codec.sv -----
// Streaming Base64 codec with the standard alphabet. The mode register
// selects encode (bytes in, characters out) or decode (characters in, bytes
// out); writing it clears any partial group, so write it between messages.
// Input bytes are taken at one per cycle while full is low; the front part
// works out the whole group for each byte in that cycle and places the work
// in a four-entry queue. The back part prints one result per cycle from that
// queue into the output register while it is empty or being popped, so the
// sustained rate is set by the result side: encode gives four characters for
// every three bytes, decode three bytes for every four characters, and one
// character can release up to six bytes when held '=' characters are flushed.
// A message that ends without a byte to deliver, or a '=' that overflows the
// held run, yields one result with no_data set.
module base64_codec
  import b64_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    mode_we,
  input  logic    mode_wdata,
  input  logic    push,
  input  item_t   item,
  output logic    full,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;
  cmd_t q_wdata;
  cmd_t q_rdata;

  b64_front u_front (
    .clk        (clk),
    .rst        (rst),
    .mode_we    (mode_we),
    .mode_wdata (mode_wdata),
    .push       (push),
    .item       (item),
    .full       (full),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_wdata)
  );

  b64_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  b64_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_rdata),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule
